>>> hdl/pwm_encoder_angle_framer_core_macros.svh
// Assertion macros used by the checker of the angle framer.
`ifndef PWM_ENCODER_ANGLE_FRAMER_CORE_MACROS_SVH
`define PWM_ENCODER_ANGLE_FRAMER_CORE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PWMENC_ASSERT_NOW(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define PWMENC_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/pwmenc_pkg.sv
package pwmenc_pkg;

  // Field and port widths.
  localparam int HT_W   = 20;
  localparam int CNT_W  = 10;
  localparam int BYTE_W = 8;
  localparam int WORD_W = 16;
  localparam int APB_AW = 3;
  localparam int APB_DW = 32;

  // Register map and reset values.
  localparam logic [APB_AW-1:0] ADDR_FRAME_INTERVAL = 3'd0;
  localparam logic [CNT_W-1:0]  INTERVAL_RST        = 10'd10;

  // Arithmetic constants.
  localparam logic [31:0] ON_SCALE    = 32'd50;          // (a*100 + b*100) / 2
  localparam logic [31:0] ANGLE_SCALE = 32'd36000;
  localparam logic [5:0]  SMOOTH_MUL  = 6'd35;
  // Reciprocals: x/36 = ((x >> 2) * RECIP9) >> 33, x/10 = ((x >> 1) * RECIP5) >> 34.
  localparam logic [29:0] RECIP9      = 30'd954437177;
  localparam logic [31:0] RECIP5      = 32'd3435973837;
  localparam logic [7:0]  CRC7_POLY   = 8'h91;

  // Frame byte positions.
  localparam logic [2:0] BYTE_TOP  = 3'd0;
  localparam logic [2:0] BYTE_HI   = 3'd2;
  localparam logic [2:0] BYTE_LO   = 3'd3;
  localparam logic [2:0] BYTE_CRC  = 3'd4;

  // Datapath operations.
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_ON,
    OP_TICK,
    OP_ANG,
    OP_MUL35,
    OP_SUM,
    OP_REC9,
    OP_DIV36,
    OP_REC5,
    OP_DIV10,
    OP_CRC_HI,
    OP_CRC_LO
  } dp_op_t;

  typedef struct packed {
    dp_op_t     op;
    logic [2:0] byte_idx;
  } dp_cmd_t;

  // One byte of the reflected CRC-7 update.
  function automatic logic [7:0] crc7_byte(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    c = crc ^ data;
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = c ^ CRC7_POLY;
      end
      c = c >> 1;
    end
    return c;
  endfunction

endpackage

>>> hdl/pwmenc_stream_if.sv
// Capture channel: two high-time counts per transfer.
interface pwmenc_in_if import pwmenc_pkg::*;;
  logic            valid;
  logic            ready;
  logic [HT_W-1:0] high_time_first;
  logic [HT_W-1:0] high_time_second;

  modport source (output valid, high_time_first, high_time_second, input ready);
  modport sink   (input valid, high_time_first, high_time_second, output ready);
endinterface

// Frame channel: one frame byte per transfer.
interface pwmenc_out_if import pwmenc_pkg::*;;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] frame_byte;
  logic              last_of_frame;

  modport source (output valid, frame_byte, last_of_frame, input ready);
  modport sink   (input valid, frame_byte, last_of_frame, output ready);
endinterface

>>> hdl/pwm_encoder_angle_framer_core.sv
// PWM encoder angle framer.
// in_ch carries one capture per transfer: two PWM high-time counts. The block
// averages them, runs the tick and angle filters and, on every frame_interval-th
// capture, sends a five-byte frame on out_ch: four value bytes, most significant
// first, then a CRC-7 byte flagged by last_of_frame.
// Sequence: one capture at a time. After the input transfer the sequencer steps
// the datapath through its single-operation arithmetic steps: ON, TICK, ANG,
// MUL35, SUM, REC9, DIV36, REC5 and DIV10. A capture without a frame raises
// in_ch.ready again after DIV10, so a new capture is taken only once the last
// one is through. With a frame, the two CRC steps CRC_HI and CRC_LO follow and
// then the first byte is valid; the five bytes then go out one per cycle while
// the receiver takes them.
// in_ch.ready is low while a capture is worked on or a frame is sent. When the
// receiver stalls, the current byte holds until it is taken.
// Reset clears the filter state and the capture count and sets frame_interval
// to ten. frame_interval is at byte address 0 of the APB port; the user must
// write it only while the block is idle; the block does not enforce this.
module pwm_encoder_angle_framer_core import pwmenc_pkg::*; #(
  parameter int CAPTURE_BITS = 20
) (
  input  logic              clk,
  input  logic              rst_n,
  pwmenc_in_if.sink         in_ch,
  pwmenc_out_if.source      out_ch,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  logic [CNT_W-1:0] interval_r;
  dp_cmd_t          cmd;

  // Configuration register.
  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      interval_r <= INTERVAL_RST;
    end else if (psel && penable && pwrite && (paddr == ADDR_FRAME_INTERVAL)) begin
      interval_r <= pwdata[CNT_W-1:0];
    end
  end

  assign prdata = (paddr == ADDR_FRAME_INTERVAL) ? APB_DW'(interval_r) : '0;

  // Sequencer.
  pwmenc_ctrl u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_ch.valid),
    .in_ready       (in_ch.ready),
    .out_valid      (out_ch.valid),
    .out_ready      (out_ch.ready),
    .frame_interval (interval_r),
    .cmd            (cmd)
  );

  // Arithmetic and framing datapath.
  pwmenc_dp #(
    .CAPTURE_BITS (CAPTURE_BITS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .high_time_first  (in_ch.high_time_first),
    .high_time_second (in_ch.high_time_second),
    .frame_byte       (out_ch.frame_byte),
    .last_of_frame    (out_ch.last_of_frame)
  );

endmodule

>>> hdl/pwmenc_dp.sv
module pwmenc_dp import pwmenc_pkg::*; #(
  parameter int CAPTURE_BITS = 20
) (
  input  logic              clk,
  input  logic              rst_n,
  input  dp_cmd_t           cmd,
  input  logic [HT_W-1:0]   high_time_first,
  input  logic [HT_W-1:0]   high_time_second,
  output logic [BYTE_W-1:0] frame_byte,
  output logic              last_of_frame
);

  localparam logic [HT_W-1:0] CapMask = (CAPTURE_BITS >= HT_W) ? {HT_W{1'b1}} :
                                        HT_W'((1 << CAPTURE_BITS) - 1);

  logic [HT_W-1:0]   a_r, b_r;
  logic [31:0]       tmp_r, tmp2_r;
  logic [63:0]       prod_r;
  logic [31:0]       st_r, sm_r;
  logic [WORD_W-1:0] word_r;
  logic [7:0]        crc_r;

  logic [HT_W:0]   sum_ab;
  logic [31:0]     on_val;
  logic [31:0]     tick_sum;
  logic [63:0]     ang_full;
  logic [37:0]     mul35_full;
  logic [59:0]     rec9_full;
  logic [62:0]     rec5_full;

  // Single-step arithmetic units used by the commands of the computation sequence.
  assign sum_ab     = {1'b0, a_r} + {1'b0, b_r};
  assign on_val     = 32'(sum_ab) * ON_SCALE;
  assign tick_sum   = tmp_r + st_r - (st_r >> 12);
  assign ang_full   = st_r * ANGLE_SCALE;
  assign mul35_full = sm_r * SMOOTH_MUL;
  assign rec9_full  = tmp_r[31:2] * RECIP9;
  assign rec5_full  = sm_r[31:1] * RECIP5;

  // Filter state, cleared at reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
      sm_r <= '0;
    end else begin
      case (cmd.op)
        OP_TICK:  st_r <= tick_sum >> 12;
        OP_DIV36: sm_r <= {1'b0, prod_r[63:33]};
        default: ;
      endcase
    end
  end

  // Working registers of the computation sequence.
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        a_r <= high_time_first & CapMask;
        b_r <= high_time_second & CapMask;
      end
      OP_ON:     tmp_r  <= on_val;
      OP_ANG:    tmp_r  <= {11'b0, ang_full[31:11]};
      OP_MUL35:  tmp2_r <= mul35_full[31:0];
      OP_SUM:    tmp_r  <= tmp_r + tmp2_r;
      OP_REC9:   prod_r <= {4'b0, rec9_full};
      OP_REC5:   prod_r <= {1'b0, rec5_full};
      OP_DIV10:  word_r <= prod_r[49:34];
      // The two leading zero bytes leave a zero CRC register unchanged.
      OP_CRC_HI: crc_r  <= crc7_byte(8'h00, word_r[15:8]);
      OP_CRC_LO: crc_r  <= crc7_byte(crc_r, word_r[7:0]);
      default: ;
    endcase
  end

  // Frame byte selection.
  always_comb begin
    case (cmd.byte_idx)
      BYTE_HI:  frame_byte = word_r[15:8];
      BYTE_LO:  frame_byte = word_r[7:0];
      BYTE_CRC: frame_byte = crc_r;
      default:  frame_byte = '0;
    endcase
  end

  assign last_of_frame = (cmd.byte_idx == BYTE_CRC);

endmodule

>>> hdl/pwmenc_ctrl.sv
module pwmenc_ctrl import pwmenc_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  input  logic [CNT_W-1:0] frame_interval,
  output dp_cmd_t          cmd
);

  typedef enum logic [12:0] {
    ST_IDLE   = 13'h0001,
    ST_ON     = 13'h0002,
    ST_TICK   = 13'h0004,
    ST_ANG    = 13'h0008,
    ST_MUL35  = 13'h0010,
    ST_SUM    = 13'h0020,
    ST_REC9   = 13'h0040,
    ST_DIV36  = 13'h0080,
    ST_REC5   = 13'h0100,
    ST_DIV10  = 13'h0200,
    ST_CRC_HI = 13'h0400,
    ST_CRC_LO = 13'h0800,
    ST_SEND   = 13'h1000
  } ctrl_state_t;

  ctrl_state_t      state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             frame_r, frame_nxt;
  logic [2:0]       idx_r, idx_nxt;
  logic             accept;
  logic [CNT_W-1:0] cnt_inc;
  logic             frame_due;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = (state_r == ST_SEND);
  assign accept    = in_valid && in_ready;

  // Capture counting: a frame is due once the new count reaches the interval.
  assign cnt_inc   = cnt_r + 1'b1;
  assign frame_due = (cnt_inc >= frame_interval);

  // Sequencer.
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    frame_nxt = frame_r;
    idx_nxt   = idx_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_ON;
          frame_nxt = frame_due;
          cnt_nxt   = frame_due ? '0 : cnt_inc;
        end
      end
      ST_ON:    state_nxt = ST_TICK;
      ST_TICK:  state_nxt = ST_ANG;
      ST_ANG:   state_nxt = ST_MUL35;
      ST_MUL35: state_nxt = ST_SUM;
      ST_SUM:   state_nxt = ST_REC9;
      ST_REC9:  state_nxt = ST_DIV36;
      ST_DIV36: state_nxt = ST_REC5;
      ST_REC5:  state_nxt = ST_DIV10;
      ST_DIV10: state_nxt = frame_r ? ST_CRC_HI : ST_IDLE;
      ST_CRC_HI: state_nxt = ST_CRC_LO;
      ST_CRC_LO: begin
        state_nxt = ST_SEND;
        idx_nxt   = BYTE_TOP;
      end
      ST_SEND: begin
        if (out_ready) begin
          if (idx_r == BYTE_CRC) begin
            state_nxt = ST_IDLE;
          end else begin
            idx_nxt = idx_r + 1'b1;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Datapath command for the current state.
  always_comb begin
    cmd.byte_idx = idx_r;
    case (state_r)
      ST_IDLE:   cmd.op = accept ? OP_LOAD : OP_NONE;
      ST_ON:     cmd.op = OP_ON;
      ST_TICK:   cmd.op = OP_TICK;
      ST_ANG:    cmd.op = OP_ANG;
      ST_MUL35:  cmd.op = OP_MUL35;
      ST_SUM:    cmd.op = OP_SUM;
      ST_REC9:   cmd.op = OP_REC9;
      ST_DIV36:  cmd.op = OP_DIV36;
      ST_REC5:   cmd.op = OP_REC5;
      ST_DIV10:  cmd.op = OP_DIV10;
      ST_CRC_HI: cmd.op = OP_CRC_HI;
      ST_CRC_LO: cmd.op = OP_CRC_LO;
      default:   cmd.op = OP_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
      frame_r <= 1'b0;
      idx_r   <= BYTE_TOP;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      frame_r <= frame_nxt;
      idx_r   <= idx_nxt;
    end
  end

endmodule

>>> hdl/pwmenc_checker.sv
`include "pwm_encoder_angle_framer_core_macros.svh"

module pwmenc_checker import pwmenc_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [BYTE_W-1:0] frame_byte,
  input logic              last_of_frame
);

  logic out_xfer;
  assign out_xfer = out_valid && out_ready;

  // A stalled byte holds its value.
  `PWMENC_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(frame_byte) && $stable(last_of_frame), "stalled frame byte changed")

  // No capture is taken while a frame is being sent.
  `PWMENC_ASSERT_NOW(a_busy_send, clk, rst_n, out_valid, !in_ready, "input ready during frame output")

  // An accepted capture makes the block busy in the next cycle.
  `PWMENC_ASSERT_NEXT(a_busy_after_in, clk, rst_n, in_valid && in_ready, !in_ready && !out_valid, "block not busy after capture transfer")

  // Frame bytes follow one another without a gap until the CRC byte.
  `PWMENC_ASSERT_NEXT(a_frame_cont, clk, rst_n, out_xfer && !last_of_frame, out_valid, "gap inside a frame")

  // The CRC byte ends the frame.
  `PWMENC_ASSERT_NEXT(a_frame_end, clk, rst_n, out_xfer && last_of_frame, !out_valid, "byte after end of frame")

endmodule

bind pwm_encoder_angle_framer_core pwmenc_checker u_pwmenc_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_ch.valid),
  .in_ready      (in_ch.ready),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .frame_byte    (out_ch.frame_byte),
  .last_of_frame (out_ch.last_of_frame)
);
